// ----- rtl/core/sliding_anagram_matcher_defines.svh -----
// ----------------------------------------------------------------------------
// Sliding anagram matcher assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_ANAGRAM_MATCHER_DEFINES_SVH
`define SLIDING_ANAGRAM_MATCHER_DEFINES_SVH

`ifndef SYNTH
`define SAM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define SAM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define SAM_ASSERT(name, clk, rst, prop)
`define SAM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/sam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding anagram matcher package
// Sizes, item kind codes and the control structs shared by the core.
// ----------------------------------------------------------------------------
package sam_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET    = 26;
   localparam int KIND_W      = 2;
   localparam int LETTER_W    = 5;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int HEAD_W      = $clog2(MAX_PATTERN);
   localparam int POS_W       = 32;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [HEAD_W-1:0]   head_type;
   typedef logic [POS_W-1:0]    pos_type;

   localparam kind_type KIND_CLEAR   = kind_type'(0);
   localparam kind_type KIND_PATTERN = kind_type'(1);
   localparam kind_type KIND_TEXT    = kind_type'(2);

   localparam pos_type POS_MAX = '1;

   typedef struct packed {
      logic       clear;
      logic       pat;
      logic       txt;
      letter_type letter;
   } sam_op_type;

   typedef struct packed {
      logic       evict;
      letter_type old_letter;
      logic       full_next;
   } sam_ring_stat_type;

endpackage

// ----- rtl/core/sam_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding anagram matcher window ring
// Holds the window letters, ring head and fill count; reports the evicted
// letter and whether the window is full after the update.
// ----------------------------------------------------------------------------
module sam_ring (
   input  logic                       clock,
   input  logic                       reset,
   input  sam_pkg::sam_op_type        op,
   input  sam_pkg::cnt_type           plen,
   output sam_pkg::sam_ring_stat_type stat
);

   sam_pkg::letter_type ring_mem [sam_pkg::MAX_PATTERN];
   sam_pkg::letter_type old_ff;
   sam_pkg::head_type   head_ff, head_in;
   sam_pkg::cnt_type    fill_ff, fill_in;
   sam_pkg::cnt_type    head_inc;
   logic                active;
   logic                full;

   always_comb begin
      active   = op.txt && (plen != '0);
      full     = (fill_ff == plen);
      head_inc = sam_pkg::cnt_type'(head_ff) + sam_pkg::cnt_type'(1);
      head_in  = head_ff;
      fill_in  = fill_ff;
      if (op.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (active) begin
         head_in = (head_inc >= plen) ? '0 : head_inc[sam_pkg::HEAD_W-1:0];
         if (!full) begin
            fill_in = fill_ff + sam_pkg::cnt_type'(1);
         end
      end
   end

   always_comb begin
      stat.evict      = active && full;
      stat.old_letter = old_ff;
      stat.full_next  = (fill_in == plen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // prefetch the slot at the next head, forwarding the letter just written
   always_ff @(posedge clock) begin
      if (active) begin
         ring_mem[head_ff] <= op.letter;
      end
      if (active && (head_in == head_ff)) begin
         old_ff <= op.letter;
      end else begin
         old_ff <= ring_mem[head_in];
      end
   end

endmodule

// ----- rtl/core/sam_hist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding anagram matcher histograms
// Pattern and window letter counts, pattern length and the anagram compare.
// ----------------------------------------------------------------------------
module sam_hist (
   input  logic                       clock,
   input  logic                       reset,
   input  sam_pkg::sam_op_type        op,
   input  sam_pkg::sam_ring_stat_type stat,
   output sam_pkg::cnt_type           plen,
   output logic                       hit
);

   sam_pkg::cnt_type pcnt_ff [sam_pkg::ALPHABET];
   sam_pkg::cnt_type pcnt_in [sam_pkg::ALPHABET];
   sam_pkg::cnt_type wcnt_ff [sam_pkg::ALPHABET];
   sam_pkg::cnt_type wcnt_in [sam_pkg::ALPHABET];
   sam_pkg::cnt_type plen_ff, plen_in;
   sam_pkg::cnt_type fcnt_ff, fcnt_in;
   logic             started_ff, started_in;
   logic             active;
   logic             new_ok;
   logic             old_ok;
   logic             pat_take;
   logic             all_eq;

   assign plen = plen_ff;

   always_comb begin
      active     = op.txt && (plen_ff != '0);
      new_ok     = (op.letter < sam_pkg::letter_type'(sam_pkg::ALPHABET));
      old_ok     = (stat.old_letter < sam_pkg::letter_type'(sam_pkg::ALPHABET));
      pat_take   = op.pat && !started_ff && new_ok &&
                   (plen_ff < sam_pkg::cnt_type'(sam_pkg::MAX_PATTERN));
      started_in = started_ff;
      plen_in    = plen_ff;
      fcnt_in    = fcnt_ff;
      all_eq     = 1'b1;
      if (op.clear) begin
         started_in = 1'b0;
         plen_in    = '0;
         fcnt_in    = '0;
      end else begin
         if (op.txt) begin
            started_in = 1'b1;
         end
         if (pat_take) begin
            plen_in = plen_ff + sam_pkg::cnt_type'(1);
         end
         fcnt_in = fcnt_ff
                 + sam_pkg::cnt_type'(active && !new_ok)
                 - sam_pkg::cnt_type'(stat.evict && !old_ok && (fcnt_ff != '0));
      end
      for (int i = 0; i < sam_pkg::ALPHABET; i++) begin
         if (op.clear) begin
            pcnt_in[i] = '0;
            wcnt_in[i] = '0;
         end else begin
            pcnt_in[i] = pcnt_ff[i]
                       + sam_pkg::cnt_type'(pat_take &&
                                            (op.letter == sam_pkg::letter_type'(i)));
            wcnt_in[i] = wcnt_ff[i]
                       + sam_pkg::cnt_type'(active && (op.letter == sam_pkg::letter_type'(i)))
                       - sam_pkg::cnt_type'(stat.evict &&
                                            (stat.old_letter == sam_pkg::letter_type'(i)) &&
                                            (wcnt_ff[i] != '0));
         end
         if (wcnt_in[i] != pcnt_ff[i]) begin
            all_eq = 1'b0;
         end
      end
      hit = all_eq && (plen_ff != '0) && stat.full_next && (fcnt_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         plen_ff    <= '0;
         fcnt_ff    <= '0;
         for (int i = 0; i < sam_pkg::ALPHABET; i++) begin
            pcnt_ff[i] <= '0;
            wcnt_ff[i] <= '0;
         end
      end else begin
         started_ff <= started_in;
         plen_ff    <= plen_in;
         fcnt_ff    <= fcnt_in;
         for (int i = 0; i < sam_pkg::ALPHABET; i++) begin
            pcnt_ff[i] <= pcnt_in[i];
            wcnt_ff[i] <= wcnt_in[i];
         end
      end
   end

endmodule

// ----- rtl/core/sliding_anagram_matcher.sv -----
`timescale 1ns / 1ps
// Path: an accepted text beat passes the input register, then the histogram
// update and compare into the result register. Throughput: one beat per
// cycle unless a text beat waits on a held result; the count update and
// 26-way compare set this figure. Clear, pattern and unused beats give no
// result. Reset: synchronous, active high; clears counts, lengths, position
// and the pipeline valids. The window ring memory is not cleared.
// ----------------------------------------------------------------------------
// Sliding anagram matcher
// Streams pattern and text letters and flags every text window that is an
// anagram of the pattern, with the window start position.
// ----------------------------------------------------------------------------
`include "sliding_anagram_matcher_defines.svh"

module sliding_anagram_matcher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sam_pkg::kind_type    req_kind,
   input  sam_pkg::letter_type  req_letter,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_match,
   output sam_pkg::pos_type     rsp_start_index
);

   logic                       s1_vld_ff, s1_vld_in;
   sam_pkg::kind_type          s1_kind_ff;
   sam_pkg::letter_type        s1_letter_ff;
   logic                       out_free;
   logic                       s1_go;
   logic                       rsp_load;
   sam_pkg::sam_op_type        op;
   sam_pkg::sam_ring_stat_type ring_stat;
   sam_pkg::cnt_type           plen;
   logic                       hit;
   sam_pkg::pos_type           pos_ff, pos_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       match_ff, match_in;
   sam_pkg::pos_type           start_ff, start_in;

   always_comb begin
      out_free  = !rsp_vld_ff || rsp_ready;
      s1_go     = s1_vld_ff && ((s1_kind_ff != sam_pkg::KIND_TEXT) || out_free);
      req_ready = !s1_vld_ff || s1_go;
      s1_vld_in = req_ready ? req_valid : s1_vld_ff;
   end

   always_comb begin
      op.clear  = 1'b0;
      op.pat    = 1'b0;
      op.txt    = 1'b0;
      op.letter = s1_letter_ff;
      case (s1_kind_ff)
         sam_pkg::KIND_CLEAR:   op.clear = s1_go;
         sam_pkg::KIND_PATTERN: op.pat   = s1_go;
         sam_pkg::KIND_TEXT:    op.txt   = s1_go;
         default:               op.clear = 1'b0;
      endcase
      rsp_load = op.txt;
   end

   sam_ring u_ring (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .plen  (plen),
      .stat  (ring_stat)
   );

   sam_hist u_hist (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .stat  (ring_stat),
      .plen  (plen),
      .hit   (hit)
   );

   always_comb begin
      pos_in = pos_ff;
      if (op.clear) begin
         pos_in = '0;
      end else if (op.txt && (pos_ff != sam_pkg::POS_MAX)) begin
         pos_in = pos_ff + sam_pkg::pos_type'(1);
      end
      match_in = hit;
      if (!hit) begin
         start_in = '0;
      end else if (pos_ff == sam_pkg::POS_MAX) begin
         start_in = sam_pkg::POS_MAX;
      end else begin
         start_in = pos_ff + sam_pkg::pos_type'(1) - sam_pkg::pos_type'(plen);
      end
      rsp_vld_in = rsp_load ? 1'b1 : (rsp_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         pos_ff     <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         pos_ff     <= pos_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_kind_ff   <= req_kind;
         s1_letter_ff <= req_letter;
      end
      if (rsp_load) begin
         match_ff <= match_in;
         start_ff <= start_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_match       = match_ff;
   assign rsp_start_index = start_ff;

   `SAM_ASSERT(a_nomatch_zero_start, clock, reset, rsp_valid && !rsp_match |-> rsp_start_index == '0)
   `SAM_ASSERT(a_stall_has_beat, clock, reset, !req_ready |-> s1_vld_ff && rsp_vld_ff)
   `SAM_ASSERT_NEXT(a_text_gives_rsp, clock, reset, op.txt, rsp_valid)
   `SAM_ASSERT_NEXT(a_clear_zeroes_pos, clock, reset, op.clear, pos_ff == '0)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding anagram matcher testbench
// Streams clear, pattern and text beats into the matcher through a bursty
// driver and checks every text result against an in-bench histogram
// predictor. A directed opening covers the corner cases, then random
// pattern/text sequences run with noise, receiver stalls and drain pauses.
// ----------------------------------------------------------------------------
module tb;
   import sam_pkg::*;

   localparam kind_type KIND_UNUSED   = kind_type'(3);
   localparam int       IDLE_LIMIT    = 4000;
   localparam int       SETTLE_CYCLES = 8;
   localparam int       RANDOM_BEATS  = 800;

   typedef struct {
      kind_type   kind;
      letter_type letter;
      bit         hold;
   } beat_type;

   typedef struct {
      logic    match;
      pos_type start;
   } verdict_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   kind_type   req_kind   = KIND_CLEAR;
   letter_type req_letter = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   logic       rsp_match;
   pos_type    rsp_start_index;

   beat_type    beat_q[$];
   verdict_type verdict_q[$];
   int          err_count = 0;

   // predictor state
   cnt_type    pat_hist[ALPHABET];
   cnt_type    win_hist[ALPHABET];
   cnt_type    pat_len;
   cnt_type    fill;
   cnt_type    foreign_cnt;
   head_type   head;
   letter_type ring[MAX_PATTERN];
   pos_type    txt_pos;
   bit         txt_seen;

   sliding_anagram_matcher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_letter      (req_letter),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match       (rsp_match),
      .rsp_start_index (rsp_start_index)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("mismatch at %0t: %s want %0h got %0h", $time, what, want, got);
      err_count++;
   endtask

   task automatic clear_histograms();
      for (int i = 0; i < ALPHABET; i++) begin
         pat_hist[i] = '0;
         win_hist[i] = '0;
      end
      pat_len     = '0;
      fill        = '0;
      foreign_cnt = '0;
      head        = '0;
      txt_pos     = '0;
      txt_seen    = 1'b0;
   endtask

   task automatic apply_beat(input kind_type kind, input letter_type letter);
      pos_type     cur;
      logic        hit;
      verdict_type v;
      case (kind)
         KIND_CLEAR: begin
            clear_histograms();
         end
         KIND_PATTERN: begin
            if (!txt_seen && pat_len < MAX_PATTERN && letter < ALPHABET) begin
               pat_hist[letter]++;
               pat_len++;
            end
         end
         KIND_TEXT: begin
            txt_seen = 1'b1;
            cur = txt_pos;
            if (txt_pos != POS_MAX) txt_pos++;
            if (pat_len != 0) begin
               if (fill == pat_len) begin
                  // evict the oldest letter of the window
                  if (ring[head] < ALPHABET) begin
                     if (win_hist[ring[head]] != 0) win_hist[ring[head]]--;
                  end else if (foreign_cnt != 0) begin
                     foreign_cnt--;
                  end
               end else begin
                  fill++;
               end
               ring[head] = letter;
               if (letter < ALPHABET) win_hist[letter]++;
               else foreign_cnt++;
               head = (head + 1 >= pat_len) ? head_type'(0) : head_type'(head + 1);
            end
            hit = (pat_len != 0) && (fill == pat_len) && (foreign_cnt == 0);
            for (int i = 0; i < ALPHABET; i++)
               if (win_hist[i] != pat_hist[i]) hit = 1'b0;
            v.match = hit;
            if (!hit) v.start = '0;
            else if (cur == POS_MAX) v.start = POS_MAX;
            else v.start = cur + 1 - pat_len;
            verdict_q.insert(verdict_q.size(), v);
         end
         default: begin
         end
      endcase
   endtask

   task automatic push_beat(input kind_type kind, input int letter, input bit hold);
      beat_type b;
      b.kind   = kind;
      b.letter = letter_type'(letter);
      b.hold   = hold;
      beat_q.insert(beat_q.size(), b);
   endtask

   function automatic int pick_letter(input int base, input int span, input int foreign_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < foreign_pct) return $urandom_range(ALPHABET, 31);
      if (roll < foreign_pct + 3) return $urandom_range(0, ALPHABET - 1);
      return (base + $urandom_range(0, span) > ALPHABET - 1) ?
         ALPHABET - 1 : base + $urandom_range(0, span);
   endfunction

   // driver
   int       gap_left   = 0;
   int       burst_left = 0;
   logic     offer;
   beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            apply_beat(req_kind, req_letter);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (beat_q.size() > 0 && !(beat_q[0].hold && verdict_q.size() > 0)) begin
               next_beat = beat_q.pop_front();
               req_kind   <= next_beat.kind;
               req_letter <= next_beat.letter;
               offer = 1'b1;
               if (burst_left == 0) begin
                  gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                  burst_left = ($urandom_range(0, 4) == 0) ?
                     $urandom_range(40, 120) : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // receiver and checker
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_tick = 0;
   verdict_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               report("result beat with nothing pending", 32'd0, rsp_start_index);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_match !== want.match)
                  report("match", want.match, rsp_match);
               if (rsp_start_index !== want.start)
                  report("start_index", want.start, rsp_start_index);
            end
         end
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         rx_tick++;
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ((rx_tick % 16) < 4);
         endcase
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   int plen;
   int tlen;
   int base;
   int span;
   int roll;

   initial begin
      clear_histograms();

      // text with an empty pattern, then an unused kind
      push_beat(KIND_TEXT, 0, 0);
      push_beat(KIND_UNUSED, 31, 0);
      push_beat(KIND_CLEAR, 0, 0);
      // foreign pattern letter, then pattern "abz"
      push_beat(KIND_PATTERN, 31, 0);
      push_beat(KIND_PATTERN, 0, 0);
      push_beat(KIND_PATTERN, 1, 0);
      push_beat(KIND_PATTERN, 25, 0);
      push_beat(KIND_TEXT, 1, 0);
      push_beat(KIND_TEXT, 0, 0);
      push_beat(KIND_TEXT, 25, 0);
      // late pattern letter
      push_beat(KIND_PATTERN, 2, 0);
      push_beat(KIND_TEXT, 0, 0);
      push_beat(KIND_TEXT, 1, 0);
      // foreign text letter in the window
      push_beat(KIND_TEXT, 30, 0);
      push_beat(KIND_TEXT, 25, 0);
      push_beat(KIND_TEXT, 0, 0);
      push_beat(KIND_TEXT, 1, 0);
      // hold until drained, then a one-letter pattern
      push_beat(KIND_CLEAR, 31, 1);
      push_beat(KIND_PATTERN, 16, 0);
      push_beat(KIND_TEXT, 16, 0);
      push_beat(KIND_TEXT, 15, 0);
      push_beat(KIND_TEXT, 16, 0);

      while (beat_q.size() < RANDOM_BEATS + 22) begin
         if ($urandom_range(0, 99) < 85) begin
            push_beat(KIND_CLEAR, $urandom_range(0, 31), $urandom_range(0, 9) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 75) plen = $urandom_range(1, 5);
            else if (roll < 92) plen = $urandom_range(6, 20);
            else plen = $urandom_range(MAX_PATTERN - 8, MAX_PATTERN + 6);
            base = $urandom_range(0, ALPHABET - 1);
            span = $urandom_range(0, 3);
            for (int i = 0; i < plen; i++)
               push_beat(KIND_PATTERN, pick_letter(base, span, 3), 0);
            tlen = $urandom_range(plen, 2 * plen + 12);
            for (int i = 0; i < tlen; i++) begin
               roll = $urandom_range(0, 99);
               if (roll < 2) push_beat(KIND_PATTERN, $urandom_range(0, 31), 0);
               else if (roll < 4) push_beat(KIND_UNUSED, $urandom_range(0, 31), 0);
               else push_beat(KIND_TEXT, pick_letter(base, span, 4), 0);
            end
         end else begin
            tlen = $urandom_range(1, 8);
            for (int i = 0; i < tlen; i++)
               push_beat(kind_type'($urandom_range(0, 3)), $urandom_range(0, 31), 0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (beat_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (err_count == 0 && verdict_q.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sam_pkg.sv
rtl/core/sam_ring.sv
rtl/core/sam_hist.sv
rtl/core/sliding_anagram_matcher.sv
tb/tb.sv
